### rtl/core/absch_pkg.sv
// Shared types, constants and register map of the adaptive beacon scheduler.
package absch_pkg;

  // Field widths
  localparam int unsigned SPEED_W    = 24;
  localparam int unsigned COURSE_W   = 26;
  localparam int unsigned FIX_W      = 3;
  localparam int unsigned SECONDS_W  = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SPD_CFG_W  = 10;
  localparam int unsigned TURN_W     = 8;

  // Configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SMART_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIXED_INTERVAL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_SPEED      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAST_SPEED     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_RATE      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FAST_RATE      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TURN_ANGLE     = 3'd6;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] RST_FIXED_INTERVAL = 16'd60;
  localparam logic [SPD_CFG_W-1:0]  RST_LOW_SPEED      = 10'd5;
  localparam logic [SPD_CFG_W-1:0]  RST_FAST_SPEED     = 10'd70;
  localparam logic [INTERVAL_W-1:0] RST_SLOW_RATE      = 16'd600;
  localparam logic [INTERVAL_W-1:0] RST_FAST_RATE      = 16'd60;
  localparam logic [TURN_W-1:0]     RST_TURN_ANGLE     = 8'd30;

  // Arithmetic constants
  localparam int unsigned KMH_W     = 20;
  localparam int unsigned KMH_SHIFT = 16;
  localparam int unsigned MUL_A_W   = SPEED_W;
  localparam int unsigned MUL_B_W   = 21;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] KMH_MUL = 21'd2359;

  localparam int unsigned CRS_W = 9;
  localparam logic [CRS_W-1:0] COURSE_MAX = 9'd359;
  localparam logic [INTERVAL_W-1:0] QUICK_INTERVAL = 16'd10;
  localparam logic [FIX_W-1:0] FIX_3D = 3'd3;

  // Course to degrees: 100000 = 32 * 3125, so drop five bits and multiply the
  // 21-bit rest by the reciprocal of 3125 scaled by 2^32, exact for any 21-bit value
  localparam int unsigned CRS_PRE_SHIFT   = 5;
  localparam int unsigned CRS_RECIP_SHIFT = 32;
  localparam int unsigned CRS_QUO_W       = 10;
  localparam logic [MUL_B_W-1:0] COURSE_RECIP = 21'd1374390;

  // Shared divider
  localparam int unsigned NUM_W  = COURSE_W;
  localparam int unsigned DEN_W  = 17;
  localparam int unsigned QUO_W  = INTERVAL_W;
  localparam int unsigned STEP_W = 5;
  localparam logic [DEN_W-1:0]  COURSE_DIV    = 17'd100000;
  localparam logic [STEP_W-1:0] INTERP_STEPS  = 5'd16;
  localparam int unsigned COURSE_QUO_MAX = ((1 << NUM_W) - 1) / 100000;

  // Frame kinds
  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOFIX     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POSITION  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIXOK_POS = 2'd3;

  typedef struct packed {
    logic                  smart_mode;
    logic [INTERVAL_W-1:0] fixed_interval;
    logic [SPD_CFG_W-1:0]  low_speed;
    logic [SPD_CFG_W-1:0]  fast_speed;
    logic [INTERVAL_W-1:0] slow_rate;
    logic [INTERVAL_W-1:0] fast_rate;
    logic [TURN_W-1:0]     turn_angle;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                  send_now;
    logic [KIND_W-1:0]     frame_kind;
    logic [INTERVAL_W-1:0] interval_used;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KMH,
    ST_CRS,
    ST_RATE,
    ST_IDIV_GO,
    ST_IDIV_WAIT,
    ST_TURN,
    ST_DONE
  } absch_state_e;

endpackage

### rtl/core/absch_cfg_regs.sv
// APB register file holding the scheduler configuration.
module absch_cfg_regs
  import absch_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign cfg_o  = cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smart_mode     <= 1'b1;
      cfg_q.fixed_interval <= RST_FIXED_INTERVAL;
      cfg_q.low_speed      <= RST_LOW_SPEED;
      cfg_q.fast_speed     <= RST_FAST_SPEED;
      cfg_q.slow_rate      <= RST_SLOW_RATE;
      cfg_q.fast_rate      <= RST_FAST_RATE;
      cfg_q.turn_angle     <= RST_TURN_ANGLE;
    end else if (wr_en) begin
      case (idx)
        REG_SMART_MODE:     cfg_q.smart_mode     <= pwdata[0];
        REG_FIXED_INTERVAL: cfg_q.fixed_interval <= pwdata[INTERVAL_W-1:0];
        REG_LOW_SPEED:      cfg_q.low_speed      <= pwdata[SPD_CFG_W-1:0];
        REG_FAST_SPEED:     cfg_q.fast_speed     <= pwdata[SPD_CFG_W-1:0];
        REG_SLOW_RATE:      cfg_q.slow_rate      <= pwdata[INTERVAL_W-1:0];
        REG_FAST_RATE:      cfg_q.fast_rate      <= pwdata[INTERVAL_W-1:0];
        REG_TURN_ANGLE:     cfg_q.turn_angle     <= pwdata[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      REG_SMART_MODE:     prdata = PDATA_W'(cfg_q.smart_mode);
      REG_FIXED_INTERVAL: prdata = PDATA_W'(cfg_q.fixed_interval);
      REG_LOW_SPEED:      prdata = PDATA_W'(cfg_q.low_speed);
      REG_FAST_SPEED:     prdata = PDATA_W'(cfg_q.fast_speed);
      REG_SLOW_RATE:      prdata = PDATA_W'(cfg_q.slow_rate);
      REG_FAST_RATE:      prdata = PDATA_W'(cfg_q.fast_rate);
      REG_TURN_ANGLE:     prdata = PDATA_W'(cfg_q.turn_angle);
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/core/absch_div.sv
// Shared restoring divider, one quotient bit per cycle.
module absch_div
  import absch_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [NUM_W-1:0]  num_hi;
  logic [STEP_W-1:0] lo_shift;

  // One restoring step: bring down the next dividend bit and try the divisor
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
  assign num_d = {num_q[NUM_W-2:0], 1'b0};
  assign quo_d = {quo_q[QUO_W-2:0], fits};

  // Split the dividend: high bits seed the remainder, low bits feed the steps
  assign num_hi   = req_i.num >> req_i.steps;
  assign lo_shift = STEP_W'(NUM_W) - req_i.steps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (req_i.start) begin
        cnt_q <= req_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  // Load operands on start, then iterate
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_hi[DEN_W-1:0];
      num_q <= req_i.num << lo_shift;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### rtl/core/absch_core.sv
// Sequencer and datapath: speed, course, interval choice and beacon decision.
module absch_core
  import absch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SPEED_W-1:0]   speed_raw_i,
  input  logic [COURSE_W-1:0]  course_raw_i,
  input  logic [FIX_W-1:0]     fix_type_i,
  input  logic [SECONDS_W-1:0] seconds_now_i,
  output div_req_t             div_req_o,
  input  div_rsp_t             div_rsp_i,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output res_t                 res_o
);

  absch_state_e state_q, state_d;

  // Captured item and working values
  logic [SPEED_W-1:0]    speed_q;
  logic [COURSE_W-1:0]   course_raw_q;
  logic [FIX_W-1:0]      fix_q;
  logic [SECONDS_W-1:0]  now_q;
  logic [PROD_W-1:0]     prod_q;
  logic [KMH_W-1:0]      kmh_q;
  logic [CRS_W-1:0]      course_q;
  logic [INTERVAL_W-1:0] rate_q;
  res_t                  res_q;

  // Scheduler state
  logic [SECONDS_W-1:0]  last_send_q;
  logic [CRS_W-1:0]      prev_course_q;
  logic                  sent_once_q;
  logic                  nofix_sent_q;

  logic                  accept;
  logic                  rate_up;
  logic [INTERVAL_W-1:0] diff;
  logic [SPD_CFG_W-1:0]  span;
  logic [SPD_CFG_W-1:0]  kmh_off;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  logic                  is_slow;
  logic                  is_fast;
  logic [CRS_W-1:0]      turn9;
  logic [CRS_W-1:0]      turn_lim;
  logic [CRS_W-1:0]      dlt;
  logic [CRS_W-1:0]      dlt1;
  logic [CRS_W-1:0]      dlt2;
  logic                  quick;
  logic [INTERVAL_W-1:0] interval;
  logic [SECONDS_W-1:0]  elapsed;
  logic                  send;
  logic [KIND_W-1:0]     kind;
  logic [CRS_QUO_W-1:0]  crs_quo;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // Rate span and direction of the linear map
  assign rate_up = cfg_i.fast_rate > cfg_i.slow_rate;
  assign diff    = rate_up ? cfg_i.fast_rate - cfg_i.slow_rate
                           : cfg_i.slow_rate - cfg_i.fast_rate;
  assign span    = cfg_i.fast_speed - cfg_i.low_speed;
  assign kmh_off = kmh_q[SPD_CFG_W-1:0] - cfg_i.low_speed;
  assign is_slow = kmh_q <= KMH_W'(cfg_i.low_speed);
  assign is_fast = kmh_q >= KMH_W'(cfg_i.fast_speed);

  // Shared multiplier: speed scaling, course reciprocal, then the interpolation product
  always_comb begin
    mul_a = MUL_A_W'(kmh_off);
    mul_b = MUL_B_W'(diff);
    case (state_q)
      ST_KMH: begin
        mul_a = speed_q;
        mul_b = KMH_MUL;
      end
      ST_CRS: begin
        mul_a = MUL_A_W'(course_raw_q[COURSE_W-1:CRS_PRE_SHIFT]);
        mul_b = COURSE_RECIP;
      end
      default: ;
    endcase
  end
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Whole degrees from the reciprocal product
  assign crs_quo = prod_q[CRS_RECIP_SHIFT +: CRS_QUO_W];

  // Course change with the north wrap
  assign turn9    = CRS_W'(cfg_i.turn_angle);
  assign turn_lim = COURSE_MAX - turn9;
  assign dlt  = (prev_course_q > course_q) ? prev_course_q - course_q
                                            : course_q - prev_course_q;
  assign dlt1 = (prev_course_q > turn_lim && course_q < turn9) ? COURSE_MAX - dlt : dlt;
  assign dlt2 = (prev_course_q < turn9 && course_q > turn_lim) ? COURSE_MAX - dlt1 : dlt1;

  // Interval and beacon decision
  assign quick = (dlt2 > turn9) && (kmh_q > KMH_W'(cfg_i.low_speed)) &&
                 (rate_q > QUICK_INTERVAL);
  assign interval = !cfg_i.smart_mode ? cfg_i.fixed_interval :
                    quick             ? QUICK_INTERVAL       : rate_q;
  assign elapsed  = now_q - last_send_q;
  assign send     = (elapsed > SECONDS_W'(interval)) || (!sent_once_q && fix_q >= FIX_3D);

  always_comb begin
    kind = KIND_NONE;
    if (send) begin
      if (fix_q < FIX_3D) begin
        kind = KIND_NOFIX;
      end else if (nofix_sent_q) begin
        kind = KIND_FIXOK_POS;
      end else begin
        kind = KIND_POSITION;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_KMH;
      ST_KMH:       state_d = ST_CRS;
      ST_CRS:       state_d = ST_RATE;
      ST_RATE: begin
        if (is_slow || is_fast) begin
          state_d = ST_TURN;
        end else begin
          state_d = ST_IDIV_GO;
        end
      end
      ST_IDIV_GO:   state_d = ST_IDIV_WAIT;
      ST_IDIV_WAIT: if (div_rsp_i.done) state_d = ST_TURN;
      ST_TURN:      state_d = ST_DONE;
      ST_DONE:      if (out_free_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    res_valid_o     = (state_q == ST_DONE) && out_free_i;
    div_req_o.start = (state_q == ST_IDIV_GO);
    div_req_o.num   = prod_q[NUM_W-1:0];
    div_req_o.den   = DEN_W'(span);
    div_req_o.steps = INTERP_STEPS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commit scheduler state once the decision is made
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_send_q   <= '0;
      prev_course_q <= '0;
      sent_once_q   <= 1'b0;
      nofix_sent_q  <= 1'b0;
    end else if (state_q == ST_TURN) begin
      if (cfg_i.smart_mode) begin
        prev_course_q <= course_q;
      end
      if (send) begin
        sent_once_q <= 1'b1;
        last_send_q <= now_q;
        if (fix_q < FIX_3D) begin
          nofix_sent_q <= 1'b1;
        end else begin
          nofix_sent_q <= 1'b0;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          speed_q      <= speed_raw_i;
          course_raw_q <= course_raw_i;
          fix_q        <= fix_type_i;
          now_q        <= seconds_now_i;
        end
      end
      ST_KMH: prod_q <= prod;
      ST_CRS: begin
        kmh_q  <= prod_q[KMH_SHIFT +: KMH_W];
        prod_q <= prod;
      end
      ST_RATE: begin
        // Saturate the course to whole degrees
        course_q <= (crs_quo > CRS_QUO_W'(COURSE_MAX)) ? COURSE_MAX : crs_quo[CRS_W-1:0];
        if (is_slow) begin
          rate_q <= cfg_i.slow_rate;
        end else if (is_fast) begin
          rate_q <= cfg_i.fast_rate;
        end else begin
          prod_q <= prod;
        end
      end
      ST_IDIV_WAIT: begin
        if (div_rsp_i.done) begin
          rate_q <= rate_up ? cfg_i.slow_rate + div_rsp_i.quo
                            : cfg_i.slow_rate - div_rsp_i.quo;
        end
      end
      ST_TURN: begin
        res_q.send_now      <= send;
        res_q.frame_kind    <= kind;
        res_q.interval_used <= interval;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  // The interpolation step never leaves the span between the two rates
  a_interp_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDIV_WAIT && div_rsp_i.done) |-> div_rsp_i.quo <= diff)
    else $error("interpolation step exceeds rate span");

  // Course quotient stays within what a 26-bit raw course can give
  a_course_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RATE) |-> crs_quo <= CRS_QUO_W'(COURSE_QUO_MAX))
    else $error("course quotient out of range");

  // A result sends a frame exactly when it flags a beacon
  a_kind_matches_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.send_now == (res_o.frame_kind != KIND_NONE)))
    else $error("frame kind disagrees with send flag");

  // The first beacon is recorded only at the decision step
  a_sent_once_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sent_once_q) |-> $past(state_q) == ST_TURN)
    else $error("sent flag set outside the decision step");
`endif

endmodule

### rtl/core/adaptive_beacon_scheduler_unit.sv
// Top level of the adaptive beacon scheduler: registers, sequencer, divider, output stage.
// Each GPS report is taken as one item and gives exactly one result item. One shared
// multiplier first scales the speed to km/h, then turns the course into whole degrees by
// a reciprocal multiplication. When the speed lies at or outside the low and fast
// thresholds, the sequencer steps through the speed, course, rate, turn and done states.
// When the speed lies between the thresholds, a third multiplier pass and a 16-step
// pass of the shared bit-serial divider interpolate the interval between the rate and
// turn states. Fixed mode runs the same sequence, so its timing follows the speed in
// the same way. The input stalls while an item is being worked on; the result sits in
// an output register, so the next item is taken while it waits, and a result still
// held there when the following one is ready stalls the sequencer.
// Configuration sits in an APB register file at byte addresses 4*i.
module adaptive_beacon_scheduler_unit
  import absch_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // GPS report channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SPEED_W-1:0]    speed_raw_i,
  input  logic [COURSE_W-1:0]   course_raw_i,
  input  logic [FIX_W-1:0]      fix_type_i,
  input  logic [SECONDS_W-1:0]  seconds_now_i,
  // Beacon decision channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  send_now_o,
  output logic [KIND_W-1:0]     frame_kind_o,
  output logic [INTERVAL_W-1:0] interval_used_o
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  res_t     out_q;
  logic     out_valid_q;
  logic     out_free;
  logic     res_valid;

  absch_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  absch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  absch_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .speed_raw_i   (speed_raw_i),
    .course_raw_i  (course_raw_i),
    .fix_type_i    (fix_type_i),
    .seconds_now_i (seconds_now_i),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_now_o      = out_q.send_now;
  assign frame_kind_o    = out_q.frame_kind;
  assign interval_used_o = out_q.interval_used;

endmodule
